@@ rtl/core/prlm_pkg.sv @@
// ----------------------------------------------------------------------------
// prlm_pkg: shared types and constants of the peak and RMS level meter
// Widths of the sample, squares, running sum and configuration registers,
// the register map, the controller states and the command bundle.
// ----------------------------------------------------------------------------
package prlm_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int MAG_W      = SAMPLE_W + 1;
    localparam int SQ_W       = 31;
    localparam int SUM_W      = 43;
    localparam int FRAC_W     = 24;
    localparam int HI_W       = SUM_W - FRAC_W;
    localparam int STEP_W     = 16;
    localparam int LEN_W      = 13;
    localparam int RECIP_W    = 25;
    localparam int LEVEL_W    = 16;
    localparam int MAX_WINDOW = 4096;
    localparam int IDX_W      = $clog2(MAX_WINDOW);
    localparam int ROOT_STEPS = 16;
    localparam int CNT_W      = $clog2(ROOT_STEPS);
    localparam int MS_W       = 31;
    localparam int ROOT_W     = 32;
    localparam int APB_DW     = 32;
    localparam int APB_AW     = 4;

    localparam logic [SUM_W-1:0]   SUM_MAX    = {SUM_W{1'b1}};
    localparam logic [MS_W-1:0]    MS_FULL    = MS_W'(1) << 30;
    localparam logic [LEVEL_W-1:0] LEVEL_FULL = 16'd32768;

    localparam logic [STEP_W-1:0]  STEP_RESET  = 16'd3;
    localparam logic [LEN_W-1:0]   LEN_RESET   = 13'd960;
    localparam logic [RECIP_W-1:0] RECIP_RESET = 25'd17476;

    typedef enum logic [1:0] {
        REG_DECAY_STEP = 2'd0,
        REG_WINDOW_LEN = 2'd1,
        REG_RECIP      = 2'd2,
        REG_UNUSED     = 2'd3
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ADD,
        ST_SUB,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_MEAN,
        ST_ROOT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic square;
        logic add;
        logic sub;
        logic mul_lo;
        logic mul_hi;
        logic mean;
        logic root;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic [STEP_W-1:0]  decay_step;
        logic [LEN_W-1:0]   window_len;
        logic [RECIP_W-1:0] window_recip;
    } t_cfg;

endpackage

@@ rtl/core/peak_and_rms_level_meter.sv @@
// ----------------------------------------------------------------------------
// peak_and_rms_level_meter: audio peak and windowed RMS level meter
// Stream in signed Q1.15 samples, stream out RMS and peak levels, one result
// per sample; APB-style configuration of decay step and RMS window.
// ----------------------------------------------------------------------------
// Each accepted sample yields one result. The sequencer works on one sample
// at a time and takes the next only once the result is handed on. Its steps,
// in order: square the sample, add the square to the running sum, remove
// the square it replaces from the ring memory, the two halves of the
// mean-square multiply on a shared multiplier and the saturation, then
// sixteen iterations of the square root, a step that hands the result to
// the output register and an idle step in which the next sample is taken.
// A finished result waits in the output register, so the next sample is
// accepted while it is not yet taken; a receiver that still holds off when
// the following result is ready holds the sequencer in its final step and so
// stalls the input. The ring needs no clearing pass: a flag records whether
// the write pointer has wrapped since the last clear, and until it has, the
// slot being replaced reads as zero. Writing a different window length clears
// the running sum and the pointer at once. Write the reciprocal register
// (Q1.24) to match the window length; a value too large saturates the RMS
// level at full scale.
// ----------------------------------------------------------------------------
module peak_and_rms_level_meter (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // stream in
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [15:0]                  s_axis_tdata,   // [15:0] sample
    // stream out
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [31:0]                  m_axis_tdata,   // [15:0] rms_level, [31:16] peak_level
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [prlm_pkg::APB_AW-1:0]  paddr,
    input  logic [prlm_pkg::APB_DW-1:0]  pwdata,
    output logic [prlm_pkg::APB_DW-1:0]  prdata,
    output logic                         pready
);

    prlm_pkg::t_cmd               w_cmd;
    prlm_pkg::t_cfg               w_cfg;
    logic                         w_clear;
    logic [prlm_pkg::LEVEL_W-1:0] w_rms;
    logic [prlm_pkg::LEVEL_W-1:0] w_peak;

    // no wait states on the register port
    assign pready = 1'b1;

    prlm_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sel    (psel),
        .i_enable (penable),
        .i_write  (pwrite),
        .i_addr   (paddr),
        .i_wdata  (pwdata),
        .o_rdata  (prdata),
        .o_cfg    (w_cfg),
        .o_clear  (w_clear)
    );

    prlm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (w_cmd)
    );

    prlm_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_cfg    (w_cfg),
        .i_clear  (w_clear),
        .i_sample (s_axis_tdata),
        .o_rms    (w_rms),
        .o_peak   (w_peak)
    );

    // pack the result item, RMS in the low half
    assign m_axis_tdata = {w_peak, w_rms};

    // an accepted item occupies the sequencer: no second item on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("item accepted while the previous one is still in work");

    // levels never exceed full scale
    a_rms_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[15:0] <= prlm_pkg::LEVEL_FULL))
        else $error("RMS level above full scale");

    a_peak_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[31:16] <= prlm_pkg::LEVEL_FULL))
        else $error("peak level above full scale");

    // a result appears only by loading from the sequencer's final step
    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid ##1 m_axis_tvalid |-> $past(w_cmd.out_load))
        else $error("result shown without a completed item");

endmodule

@@ rtl/core/prlm_regs.sv @@
// ----------------------------------------------------------------------------
// prlm_regs: configuration register bank
// APB-style write and read of decay step, window length and reciprocal;
// flags a window clear when a different window length is written.
// ----------------------------------------------------------------------------
module prlm_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_sel,
    input  logic                         i_enable,
    input  logic                         i_write,
    input  logic [prlm_pkg::APB_AW-1:0]  i_addr,
    input  logic [prlm_pkg::APB_DW-1:0]  i_wdata,
    output logic [prlm_pkg::APB_DW-1:0]  o_rdata,
    output prlm_pkg::t_cfg               o_cfg,
    output logic                         o_clear
);

    prlm_pkg::t_cfg     r_cfg;
    prlm_pkg::t_reg_idx w_idx;
    logic               w_wr;

    assign w_idx = prlm_pkg::t_reg_idx'(i_addr[3:2]);
    assign w_wr  = i_sel && i_enable && i_write;

    // a new window length restarts the window
    assign o_clear = w_wr && (w_idx == prlm_pkg::REG_WINDOW_LEN)
                     && (i_wdata[prlm_pkg::LEN_W-1:0] != r_cfg.window_len);
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.decay_step   <= prlm_pkg::STEP_RESET;
            r_cfg.window_len   <= prlm_pkg::LEN_RESET;
            r_cfg.window_recip <= prlm_pkg::RECIP_RESET;
        end else if (w_wr) begin
            unique case (w_idx)
                prlm_pkg::REG_DECAY_STEP: begin
                    r_cfg.decay_step <= i_wdata[prlm_pkg::STEP_W-1:0];
                end
                prlm_pkg::REG_WINDOW_LEN: begin
                    r_cfg.window_len <= i_wdata[prlm_pkg::LEN_W-1:0];
                end
                prlm_pkg::REG_RECIP: begin
                    r_cfg.window_recip <= i_wdata[prlm_pkg::RECIP_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            prlm_pkg::REG_DECAY_STEP: o_rdata = prlm_pkg::APB_DW'(r_cfg.decay_step);
            prlm_pkg::REG_WINDOW_LEN: o_rdata = prlm_pkg::APB_DW'(r_cfg.window_len);
            prlm_pkg::REG_RECIP:      o_rdata = prlm_pkg::APB_DW'(r_cfg.window_recip);
            default:                  o_rdata = '0;
        endcase
    end

endmodule

@@ rtl/core/prlm_ctrl.sv @@
// ----------------------------------------------------------------------------
// prlm_ctrl: sequencing state machine
// Steps one item through square, sum update, mean-square multiply and the
// square root iterations, and owns the input and output handshakes.
// ----------------------------------------------------------------------------
module prlm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output prlm_pkg::t_cmd o_cmd
);

    prlm_pkg::t_state            r_state, n_state;
    logic [prlm_pkg::CNT_W-1:0]  r_cnt, n_cnt;
    logic                        r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= prlm_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        unique case (r_state)
            prlm_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = prlm_pkg::ST_SQUARE;
                end
            end
            prlm_pkg::ST_SQUARE: begin
                o_cmd.square = 1'b1;
                n_state      = prlm_pkg::ST_ADD;
            end
            prlm_pkg::ST_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = prlm_pkg::ST_SUB;
            end
            prlm_pkg::ST_SUB: begin
                o_cmd.sub = 1'b1;
                n_state   = prlm_pkg::ST_MUL_LO;
            end
            prlm_pkg::ST_MUL_LO: begin
                o_cmd.mul_lo = 1'b1;
                n_state      = prlm_pkg::ST_MUL_HI;
            end
            prlm_pkg::ST_MUL_HI: begin
                o_cmd.mul_hi = 1'b1;
                n_state      = prlm_pkg::ST_MEAN;
            end
            prlm_pkg::ST_MEAN: begin
                o_cmd.mean = 1'b1;
                n_cnt      = '0;
                n_state    = prlm_pkg::ST_ROOT;
            end
            prlm_pkg::ST_ROOT: begin
                o_cmd.root = 1'b1;
                n_cnt      = r_cnt + 1'b1;
                if (r_cnt == prlm_pkg::CNT_W'(prlm_pkg::ROOT_STEPS - 1)) begin
                    n_state = prlm_pkg::ST_DONE;
                end
            end
            prlm_pkg::ST_DONE: begin
                // hand over once the output register is free or being emptied
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = prlm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = prlm_pkg::ST_IDLE;
            end
        endcase

        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

@@ rtl/core/prlm_dp.sv @@
// ----------------------------------------------------------------------------
// prlm_dp: level meter datapath
// Peak hold with linear decay, ring of squares with running sum, shared
// multiplier for the mean square and a bit-pair square root.
// ----------------------------------------------------------------------------
module prlm_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  prlm_pkg::t_cmd                 i_cmd,
    input  prlm_pkg::t_cfg                 i_cfg,
    input  logic                           i_clear,
    input  logic [prlm_pkg::SAMPLE_W-1:0]  i_sample,
    output logic [prlm_pkg::LEVEL_W-1:0]   o_rms,
    output logic [prlm_pkg::LEVEL_W-1:0]   o_peak
);

    localparam int PROD_W = prlm_pkg::FRAC_W + prlm_pkg::RECIP_W;
    localparam int PHI_W  = prlm_pkg::HI_W + prlm_pkg::RECIP_W;
    localparam int PLO_W  = PROD_W - prlm_pkg::FRAC_W;
    localparam int MSUM_W = PHI_W + 1;

    // state with reset values
    logic [prlm_pkg::LEVEL_W-1:0]  r_held;
    logic [prlm_pkg::SUM_W-1:0]    r_sum;
    logic [prlm_pkg::IDX_W-1:0]    r_idx;
    logic                          r_wrapped;

    // per-item working registers
    logic [prlm_pkg::SAMPLE_W-1:0] r_sample;
    logic [prlm_pkg::SQ_W-1:0]     r_sq;
    logic [prlm_pkg::SQ_W-1:0]     r_rd;
    logic [prlm_pkg::SQ_W-1:0]     r_old;
    logic [prlm_pkg::SUM_W-1:0]    r_tmp;
    logic [PLO_W-1:0]              r_plo;
    logic [PHI_W-1:0]              r_phi;
    logic [prlm_pkg::MS_W-1:0]     r_v;
    logic [prlm_pkg::ROOT_W-1:0]   r_res;
    logic [prlm_pkg::MS_W-1:0]     r_bit;
    logic [prlm_pkg::LEVEL_W-1:0]  r_rms_out;
    logic [prlm_pkg::LEVEL_W-1:0]  r_peak_out;

    logic [prlm_pkg::SQ_W-1:0]     r_ring [prlm_pkg::MAX_WINDOW];

    logic [prlm_pkg::MAG_W-1:0]    w_mag;
    logic signed [prlm_pkg::MAG_W:0] w_lowered;
    logic [2*prlm_pkg::MAG_W-1:0]  w_sq_full;
    logic [prlm_pkg::SUM_W:0]      w_add;
    logic [prlm_pkg::LEN_W-1:0]    w_len_eff;
    logic [prlm_pkg::LEN_W-1:0]    w_next;
    logic                          w_wrap;
    logic [prlm_pkg::FRAC_W-1:0]   w_mul_a;
    logic [PROD_W-1:0]             w_prod;
    logic [MSUM_W-1:0]             w_ms;
    logic [prlm_pkg::ROOT_W:0]     w_trial;
    logic                          w_take;

    assign w_mag = r_sample[prlm_pkg::SAMPLE_W-1]
                 ? prlm_pkg::MAG_W'(~{1'b1, r_sample} + 1'b1)
                 : {1'b0, r_sample};
    assign w_lowered = $signed({2'b00, r_held}) - $signed({2'b00, i_cfg.decay_step});
    assign w_sq_full = w_mag * w_mag;
    assign w_add     = {1'b0, r_sum} + (prlm_pkg::SUM_W + 1)'(r_sq);

    // zero length acts as one entry, oversize lengths saturate at the ring depth
    always_comb begin
        if (i_cfg.window_len == '0) begin
            w_len_eff = prlm_pkg::LEN_W'(1);
        end else if (i_cfg.window_len > prlm_pkg::LEN_W'(prlm_pkg::MAX_WINDOW)) begin
            w_len_eff = prlm_pkg::LEN_W'(prlm_pkg::MAX_WINDOW);
        end else begin
            w_len_eff = i_cfg.window_len;
        end
    end

    assign w_next = prlm_pkg::LEN_W'(r_idx) + 1'b1;
    assign w_wrap = (w_next >= w_len_eff);

    // one multiplier serves both halves of the sum
    assign w_mul_a = i_cmd.mul_hi ? prlm_pkg::FRAC_W'(r_sum[prlm_pkg::SUM_W-1:prlm_pkg::FRAC_W])
                                  : r_sum[prlm_pkg::FRAC_W-1:0];
    assign w_prod  = w_mul_a * i_cfg.window_recip;
    assign w_ms    = MSUM_W'(r_phi) + MSUM_W'(r_plo);

    assign w_trial = (prlm_pkg::ROOT_W + 1)'(r_res) + (prlm_pkg::ROOT_W + 1)'(r_bit);
    assign w_take  = ((prlm_pkg::ROOT_W + 1)'(r_v) >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held    <= '0;
            r_sum     <= '0;
            r_idx     <= '0;
            r_wrapped <= 1'b0;
        end else if (i_clear) begin
            r_sum     <= '0;
            r_idx     <= '0;
            r_wrapped <= 1'b0;
        end else begin
            if (i_cmd.square) begin
                if ($signed({2'b00, w_mag}) > w_lowered) begin
                    r_held <= w_mag[prlm_pkg::LEVEL_W-1:0];
                end else begin
                    r_held <= w_lowered[prlm_pkg::LEVEL_W-1:0];
                end
            end
            if (i_cmd.sub) begin
                if (r_tmp < prlm_pkg::SUM_W'(r_old)) begin
                    r_sum <= '0;
                end else begin
                    r_sum <= r_tmp - prlm_pkg::SUM_W'(r_old);
                end
                if (w_wrap) begin
                    r_idx     <= '0;
                    r_wrapped <= 1'b1;
                end else begin
                    r_idx <= w_next[prlm_pkg::IDX_W-1:0];
                end
            end
        end
    end

    // ring of squares, one port
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rd <= r_ring[r_idx];
        end
        if (i_cmd.sub) begin
            r_ring[r_idx] <= r_sq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sample <= i_sample;
        end
        if (i_cmd.square) begin
            r_sq  <= w_sq_full[prlm_pkg::SQ_W-1:0];
            // slots not yet written since the last clear read as zero
            r_old <= r_wrapped ? r_rd : '0;
        end
        if (i_cmd.add) begin
            r_tmp <= w_add[prlm_pkg::SUM_W] ? prlm_pkg::SUM_MAX : w_add[prlm_pkg::SUM_W-1:0];
        end
        if (i_cmd.mul_lo) begin
            r_plo <= w_prod[PROD_W-1:prlm_pkg::FRAC_W];
        end
        if (i_cmd.mul_hi) begin
            r_phi <= w_prod[PHI_W-1:0];
        end
        if (i_cmd.mean) begin
            r_v   <= (w_ms > MSUM_W'(prlm_pkg::MS_FULL)) ? prlm_pkg::MS_FULL
                                                         : w_ms[prlm_pkg::MS_W-1:0];
            r_res <= '0;
            r_bit <= prlm_pkg::MS_W'(1) << 30;
        end
        if (i_cmd.root) begin
            if (w_take) begin
                r_v   <= r_v - w_trial[prlm_pkg::MS_W-1:0];
                r_res <= (r_res >> 1) + prlm_pkg::ROOT_W'(r_bit);
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
        if (i_cmd.out_load) begin
            r_rms_out  <= r_res[prlm_pkg::LEVEL_W-1:0];
            r_peak_out <= r_held;
        end
    end

    assign o_rms  = r_rms_out;
    assign o_peak = r_peak_out;

endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the peak and RMS level meter
// Streams signed audio samples into the meter under a series of decay-step
// and window settings, predicts each peak and RMS level in the bench, and
// compares every result item field by field as it leaves the block.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int          RING_DEPTH   = 4096;
    localparam logic [63:0] TOTAL_CEIL   = (64'd1 << 43) - 64'd1;
    localparam logic [63:0] MEAN_CEIL    = 64'd1 << 30;
    localparam int          IDLE_LIMIT   = 5000;   // cycles without any handshake
    localparam int          HOLD_CYCLES  = 600;    // long receiver hold-off
    localparam int          SETTLE_WAIT  = 30;     // settle wait before touching the registers

    typedef struct {
        logic [15:0] rms;
        logic [15:0] peak;
    } t_level;

    // ------------------------------------------------------------------------
    // Clock, reset and block inputs, all known from time zero
    // ------------------------------------------------------------------------
    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        smp_valid = 1'b0;
    logic        smp_ready;
    logic [15:0] smp_data  = '0;
    logic        lvl_valid;
    logic        lvl_ready = 1'b0;
    logic [31:0] lvl_data;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [prlm_pkg::APB_AW-1:0] paddr  = '0;
    logic [prlm_pkg::APB_DW-1:0] pwdata = '0;
    logic [prlm_pkg::APB_DW-1:0] prdata;
    logic        pready;

    always #4 i_clk = ~i_clk;

    peak_and_rms_level_meter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (smp_valid),
        .s_axis_tready (smp_ready),
        .s_axis_tdata  (smp_data),    // [15:0] sample
        .m_axis_tvalid (lvl_valid),
        .m_axis_tready (lvl_ready),
        .m_axis_tdata  (lvl_data),    // [15:0] rms_level, [31:16] peak_level
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // ------------------------------------------------------------------------
    // Bench copy of the meter: configuration and level state
    // ------------------------------------------------------------------------
    logic [15:0] cfg_step  = 16'd3;
    logic [12:0] cfg_len   = 13'd960;
    logic [24:0] cfg_recip = 25'd17476;

    logic [15:0] pk_hold   = '0;
    logic [63:0] sq_total  = '0;
    logic [30:0] sq_hist [RING_DEPTH] = '{default: '0};
    logic [11:0] hist_ptr  = '0;

    t_level      expected_levels[$];
    logic [15:0] sample_q[$];

    int mismatches     = 0;
    int samples_in     = 0;
    int results_seen   = 0;
    int settings_count = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit pressure_armed = 1'b0;
    bit hold_done      = 1'b0;
    int hold_left      = 0;
    int quiet_cycles   = 0;
    logic signed [15:0] last_smp = '0;

    // Floor square root, one result bit at a time from the top.
    function automatic logic [15:0] floor_root(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] trial;
        r = '0;
        for (int b = 15; b >= 0; b--) begin
            trial = r | (64'd1 << b);
            if (trial * trial <= v) r = trial;
        end
        return r[15:0];
    endfunction

    // Apply a register write to the bench copy; a new window length empties
    // the window, the same length leaves it alone, unknown indexes do nothing.
    function automatic void apply_reg(input prlm_pkg::t_reg_idx idx, input logic [31:0] val);
        case (idx)
            prlm_pkg::REG_DECAY_STEP: begin
                cfg_step = val[15:0];
            end
            prlm_pkg::REG_WINDOW_LEN: begin
                if (val[12:0] != cfg_len) begin
                    cfg_len  = val[12:0];
                    sq_total = '0;
                    hist_ptr = '0;
                    foreach (sq_hist[k]) sq_hist[k] = '0;
                end
            end
            prlm_pkg::REG_RECIP: begin
                cfg_recip = val[24:0];
            end
            default: begin
            end
        endcase
    endfunction

    function automatic logic [31:0] reg_value(input prlm_pkg::t_reg_idx idx);
        case (idx)
            prlm_pkg::REG_DECAY_STEP: return {16'd0, cfg_step};
            prlm_pkg::REG_WINDOW_LEN: return {19'd0, cfg_len};
            default:                  return {7'd0, cfg_recip};
        endcase
    endfunction

    // Work out the levels one accepted sample produces and queue them.
    function automatic void predict_levels(input logic [15:0] raw);
        int          xs;
        int          mag;
        int          lowered;
        int unsigned span;
        int unsigned slot;
        logic [30:0] sq;
        logic [30:0] gone;
        logic [63:0] acc;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [63:0] mean;
        t_level      lv;

        xs  = $signed(raw);
        mag = (xs < 0) ? -xs : xs;

        // Peak: take the magnitude when it clears the lowered peak (signed
        // compare, so a step above the peak always lets the sample in).
        lowered = int'(pk_hold) - int'(cfg_step);
        if (mag > lowered) pk_hold = 16'(mag);
        else               pk_hold = 16'(lowered);

        // Window: zero length acts as one entry, oversize lengths saturate.
        span = (cfg_len == 0) ? 1 : ((cfg_len > RING_DEPTH) ? RING_DEPTH : cfg_len);
        slot = hist_ptr;
        if (slot >= span) slot = 0;
        sq   = 31'(mag * mag);
        gone = sq_hist[slot];
        acc  = sq_total + 64'(sq);
        if (acc > TOTAL_CEIL) acc = TOTAL_CEIL;
        sq_total = (acc < 64'(gone)) ? 64'd0 : acc - 64'(gone);
        sq_hist[slot] = sq;
        slot++;
        if (slot >= span) slot = 0;
        hist_ptr = 12'(slot);

        // Mean square in Q2.30, split multiply, saturated at full scale.
        hi   = sq_total >> 24;
        lo   = sq_total & 64'hFF_FFFF;
        mean = hi * 64'(cfg_recip) + ((lo * 64'(cfg_recip)) >> 24);
        if (mean > MEAN_CEIL) mean = MEAN_CEIL;

        lv.rms  = floor_root(mean);
        lv.peak = pk_hold;
        expected_levels.push_back(lv);
    endfunction

    // Random sample mix: full-range noise, quiet signal so the peak decays,
    // silence, the extremes, and repeats of the previous value.
    function automatic logic [15:0] next_sample();
        int pick;
        logic signed [15:0] s;
        pick = $urandom_range(99);
        if (pick < 30)      s = 16'($urandom);
        else if (pick < 60) s = 16'($signed($urandom_range(511)) - 256);
        else if (pick < 72) s = '0;
        else if (pick < 82) begin
            case ($urandom_range(3))
                0:       s = -16'sd32768;
                1:       s = 16'sd32767;
                2:       s = -16'sd32767;
                default: s = 16'sd1;
            endcase
        end else s = last_smp;
        last_smp = s;
        return s;
    endfunction

    // ------------------------------------------------------------------------
    // Sample driver: hold an offered item until it is taken, then advance
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            smp_valid <= 1'b0;
        end else begin
            if (smp_valid && smp_ready) begin
                predict_levels(smp_data);
                samples_in++;
            end
            if (!smp_valid || smp_ready) begin
                if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    smp_valid <= 1'b1;
                    smp_data  <= sample_q.pop_front();
                end else begin
                    smp_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: check each item against the oldest expectation; in the
    // pressure phase hold off once for a long stretch so the block backs up
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_level want;
        if (!i_rst_n) begin
            lvl_ready <= 1'b0;
        end else begin
            if (lvl_valid && lvl_ready) begin
                results_seen++;
                if (expected_levels.size() == 0) begin
                    mismatches++;
                    $display("%0t: result item with nothing pending, actual rms %0d peak %0d",
                             $time, lvl_data[15:0], lvl_data[31:16]);
                end else begin
                    want = expected_levels.pop_front();
                    if (lvl_data[15:0] !== want.rms) begin
                        mismatches++;
                        $display("%0t: rms_level mismatch, expected %0d, actual %0d",
                                 $time, want.rms, lvl_data[15:0]);
                    end
                    if (lvl_data[31:16] !== want.peak) begin
                        mismatches++;
                        $display("%0t: peak_level mismatch, expected %0d, actual %0d",
                                 $time, want.peak, lvl_data[31:16]);
                    end
                end
            end
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                lvl_ready <= 1'b0;
            end else if (pressure_armed && !hold_done && lvl_valid) begin
                hold_left <= HOLD_CYCLES;
                hold_done <= 1'b1;
                lvl_ready <= 1'b0;
            end else begin
                lvl_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: drop the run if no item moves for too long; results that
    // nothing asked for do not count as progress
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((smp_valid && smp_ready) ||
            (lvl_valid && lvl_ready && expected_levels.size() != 0) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Configuration port: setup cycle then access cycle
    // ------------------------------------------------------------------------
    task automatic apb_write(input prlm_pkg::t_reg_idx idx, input logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        apply_reg(idx, val);
    endtask

    // Read a register back; sample mid-way through the access cycle.
    task automatic apb_check(input prlm_pkg::t_reg_idx idx);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        if (prdata !== reg_value(idx)) begin
            mismatches++;
            $display("%0t: register %s read mismatch, expected %0d, actual %0d",
                     $time, idx.name(), reg_value(idx), prdata);
        end
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_regs();
        apb_check(prlm_pkg::REG_DECAY_STEP);
        apb_check(prlm_pkg::REG_WINDOW_LEN);
        apb_check(prlm_pkg::REG_RECIP);
    endtask

    task automatic set_meter(input logic [31:0] step, input logic [31:0] len,
                             input logic [31:0] recip);
        apb_write(prlm_pkg::REG_DECAY_STEP, step);
        apb_write(prlm_pkg::REG_WINDOW_LEN, len);
        apb_write(prlm_pkg::REG_RECIP, recip);
        check_regs();
        settings_count++;
    endtask

    // Wait until every queued sample is taken and every level has come back,
    // then let the block settle before touching its registers.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (sample_q.size() != 0 || smp_valid || expected_levels.size() != 0);
        repeat (SETTLE_WAIT) @(posedge i_clk);
    endtask

    task automatic run_samples(input int count, input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < count; i++) sample_q.push_back(next_sample());
        wait_drained();
    endtask

    // ------------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset values, then the directed samples: the extremes, alternating
        // bit patterns, and a loud sample followed by silence to watch decay.
        check_regs();
        settings_count++;
        sample_q = '{16'h8000, 16'h7FFF, 16'h8001, 16'hFFFF, 16'h0001, 16'h0000,
                     16'h5555, 16'hAAAA, 16'd100, 16'hFF9C,
                     16'h0000, 16'h0000, 16'h0000, 16'h0000,
                     16'h0000, 16'h0000, 16'h0000, 16'h0000,
                     16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000};
        wait_drained();
        run_samples(80, 0, 0);

        // Single-entry window, no decay at all.
        set_meter(32'h0000_0000, 32'd1, 32'd16777216);
        run_samples(100, 58, 0);

        // Zero length acts as one entry; step above any peak. Upper bits of
        // the write data are set to prove they are dropped.
        set_meter(32'hFFFF_FFFF, 32'hFFFF_E000, 32'd16777216);
        run_samples(100, 0, 58);

        // Pressure: the receiver holds off once while samples keep coming.
        set_meter(32'd100, 32'd16, 32'd1048576);
        pressure_armed = 1'b1;
        run_samples(150, 20, 20);
        pressure_armed = 1'b0;

        // Same length again keeps the window; an unknown register is ignored.
        set_meter(32'd32768, 32'd16, 32'd1048576);
        apb_write(prlm_pkg::REG_UNUSED, 32'hFFFF_FFFF);
        check_regs();
        run_samples(100, 0, 0);

        set_meter(32'd7, 32'd37, 32'd453438);
        run_samples(150, 58, 0);

        // Reciprocal far too large: RMS saturates at full scale.
        set_meter(32'd7, 32'd5, 32'h01FF_FFFF);
        run_samples(100, 0, 58);

        // Zero reciprocal: RMS reads zero.
        set_meter(32'd7, 32'd5, 32'd0);
        run_samples(50, 20, 20);

        // Oversize length saturates to the full ring, then the true maximum.
        set_meter(32'd1, 32'd8191, 32'd4096);
        run_samples(120, 0, 0);
        set_meter(32'd1, 32'd4096, 32'd4096);
        run_samples(80, 58, 0);

        set_meter(32'd512, 32'd100, 32'd167772);
        run_samples(200, 20, 20);

        set_meter(32'd50, 32'd2, 32'd8388608);
        run_samples(100, 0, 58);

        if (expected_levels.size() != 0) begin
            mismatches++;
            $display("%0t: %0d expected results never arrived", $time, expected_levels.size());
        end

        $display("Streamed %0d samples and checked %0d level results over %0d meter settings,",
                 samples_in, results_seen, settings_count);
        $display("window lengths from zero to beyond the ring, with idle, stall and hold-off.");
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
